FILE: hw/rtl/parametric_curve_evaluator_unit_assert.svh
// Assertion macros used by the curve evaluator checker.
`ifndef PARAMETRIC_CURVE_EVALUATOR_UNIT_ASSERT_SVH
`define PARAMETRIC_CURVE_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("curve evaluator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("curve evaluator assertion failed");

`endif

FILE: hw/rtl/pce_pkg.sv
// Types, widths and constants of the parametric curve evaluator.
package pce_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned U_W      = FRAC_BITS + 1;
  localparam int unsigned SQ_W     = 2 * FRAC_BITS + 1;
  localparam int unsigned CUBE_W   = SQ_W + U_W;
  localparam int unsigned WGT_W    = 2 * FRAC_BITS + 3;
  localparam int unsigned PROD_W   = COORD_WIDTH + WGT_W;
  localparam int unsigned ACC_W    = PROD_W + 2;
  localparam int unsigned SHIFT_BZ = 2 * FRAC_BITS;
  localparam int unsigned SHIFT_CR = SHIFT_BZ + 1;

  localparam int unsigned PIPE_DEPTH = 6;
  localparam int unsigned DEPTH_W    = $clog2(PIPE_DEPTH + 2);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [U_W-1:0]                tpar_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [CUBE_W-1:0]             cube_t;
  typedef logic signed [WGT_W-1:0]       wgt_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  typedef enum logic [1:0] {
    KIND_CATMULL = 2'd0,
    KIND_QUAD    = 2'd1,
    KIND_CUBIC   = 2'd2
  } curve_kind_e;

  typedef struct packed {
    coord_t [3:0] pts;
    wgt_t   [3:0] wgts;
    curve_kind_e  kind;
  } wgt_req_t;

  localparam tpar_t  ONE_T     = U_W'(1) << FRAC_BITS;
  localparam cube_t  CUBE_HALF = CUBE_W'(1) << (FRAC_BITS - 1);
  localparam wgt_t   ONE_S     = WGT_W'(1) << SHIFT_BZ;
  localparam acc_t   HALF_BZ   = ACC_W'(1) << (SHIFT_BZ - 1);
  localparam acc_t   HALF_CR   = ACC_W'(1) << (SHIFT_CR - 1);
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

endpackage

FILE: hw/rtl/pce_if.sv
// Request and result channel interfaces of the curve evaluator.
interface pce_in_if;
  import pce_pkg::*;

  logic   valid;
  logic   ready;
  coord_t point_a;
  coord_t point_b;
  coord_t point_c;
  coord_t point_d;
  tpar_t  t_param;

  modport source (output valid, output point_a, output point_b, output point_c,
                  output point_d, output t_param, input ready);
  modport sink (input valid, input point_a, input point_b, input point_c,
                input point_d, input t_param, output ready);
endinterface

interface pce_out_if;
  import pce_pkg::*;

  logic   valid;
  logic   ready;
  coord_t curve_value;

  modport source (output valid, output curve_value, input ready);
  modport sink (input valid, input curve_value, output ready);
endinterface

FILE: hw/rtl/parametric_curve_evaluator_unit.sv
// Top level of the parametric curve evaluator.
// Evaluates one Q16.16 coordinate of a Catmull-Rom, quadratic Bezier or cubic
// Bezier curve per request, with t clamped to 1.0 and the result rounded to
// nearest and saturated. The pipeline is six register stages deep, and one
// request can be accepted every cycle while the result side does not stall.
// Each stage holds its data until the next stage has room, so backpressure
// ripples back to the request side only once the pipeline is full. The curve
// kind is sampled with each request and must only be written while no request
// is in flight.
module parametric_curve_evaluator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  pce_in_if.sink     req_i,
  pce_out_if.source  res_o
);
  import pce_pkg::*;

  curve_kind_e kind_q;
  logic        wgt_valid;
  logic        wgt_ready;
  wgt_req_t    wgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_CATMULL;
    end else if (cfg_we_i) begin
      kind_q <= curve_kind_e'(cfg_data_i);
    end
  end

  pce_weight_gen u_weight_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_q),
    .req_i       (req_i),
    .wgt_valid_o (wgt_valid),
    .wgt_ready_i (wgt_ready),
    .wgt_o       (wgt)
  );

  pce_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wgt_valid_i (wgt_valid),
    .wgt_ready_o (wgt_ready),
    .wgt_i       (wgt),
    .res_o       (res_o)
  );

endmodule

FILE: hw/rtl/pce_weight_gen.sv
// Three-stage pipeline that forms the powers of t and the four basis weights.
module pce_weight_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pce_pkg::curve_kind_e kind_i,
  pce_in_if.sink               req_i,
  output logic                 wgt_valid_o,
  input  logic                 wgt_ready_i,
  output pce_pkg::wgt_req_t    wgt_o
);
  import pce_pkg::*;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  tpar_t        u_clamp, s_c;
  coord_t [3:0] pts1_q, pts2_q;
  tpar_t        u1_q, u2_q;
  sq_t          t2_1_q, ss1_q, su1_q;
  sq_t          t2_2_q, t3_2_q, ss2_q, su2_q;
  curve_kind_e  kind1_q, kind2_q;
  cube_t        cube;
  sq_t          t3_d;
  wgt_t         t1w, t2w, t3w, ssw, suw;
  wgt_t [3:0]   wgt_d;
  wgt_req_t     out_q;

  assign en3 = !v3_q || wgt_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign req_i.ready = en1;
  assign wgt_valid_o = v3_q;
  assign wgt_o = out_q;

  assign u_clamp = (req_i.t_param > ONE_T) ? ONE_T : req_i.t_param;
  assign s_c     = ONE_T - u_clamp;

  assign cube = CUBE_W'(t2_1_q) * CUBE_W'(u1_q);
  assign t3_d = SQ_W'((cube + CUBE_HALF) >> FRAC_BITS);

  assign t1w = WGT_W'(u2_q) << FRAC_BITS;
  assign t2w = WGT_W'(t2_2_q);
  assign t3w = WGT_W'(t3_2_q);
  assign ssw = WGT_W'(ss2_q);
  assign suw = WGT_W'(su2_q);

  always_comb begin
    case (kind2_q)
      KIND_CATMULL: begin
        wgt_d[0] = WGT_W'(2) * t2w - t1w - t3w;
        wgt_d[1] = WGT_W'(2) * ONE_S - WGT_W'(5) * t2w + WGT_W'(3) * t3w;
        wgt_d[2] = t1w + WGT_W'(4) * t2w - WGT_W'(3) * t3w;
        wgt_d[3] = t3w - t2w;
      end
      KIND_QUAD: begin
        wgt_d[0] = ssw;
        wgt_d[1] = WGT_W'(2) * suw;
        wgt_d[2] = t2w;
        wgt_d[3] = '0;
      end
      default: begin
        wgt_d[0] = ONE_S - WGT_W'(3) * t1w + WGT_W'(3) * t2w - t3w;
        wgt_d[1] = WGT_W'(3) * t1w - WGT_W'(6) * t2w + WGT_W'(3) * t3w;
        wgt_d[2] = WGT_W'(3) * t2w - WGT_W'(3) * t3w;
        wgt_d[3] = t3w;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= req_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pts1_q  <= {req_i.point_d, req_i.point_c, req_i.point_b, req_i.point_a};
      u1_q    <= u_clamp;
      t2_1_q  <= SQ_W'(u_clamp) * SQ_W'(u_clamp);
      ss1_q   <= SQ_W'(s_c) * SQ_W'(s_c);
      su1_q   <= SQ_W'(s_c) * SQ_W'(u_clamp);
      kind1_q <= kind_i;
    end
    if (en2) begin
      pts2_q  <= pts1_q;
      u2_q    <= u1_q;
      t2_2_q  <= t2_1_q;
      t3_2_q  <= t3_d;
      ss2_q   <= ss1_q;
      su2_q   <= su1_q;
      kind2_q <= kind1_q;
    end
    if (en3) begin
      out_q.pts  <= pts2_q;
      out_q.wgts <= wgt_d;
      out_q.kind <= kind2_q;
    end
  end

endmodule

FILE: hw/rtl/pce_mac.sv
// Three-stage pipeline that multiplies, sums, rounds and saturates the result.
module pce_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wgt_valid_i,
  output logic              wgt_ready_o,
  input  pce_pkg::wgt_req_t wgt_i,
  pce_out_if.source         res_o
);
  import pce_pkg::*;

  logic en4, en5, en6;
  logic v4_q, v5_q, v6_q;

  prod_t [3:0] prod_d, prod_q;
  curve_kind_e kind4_q, kind5_q;
  acc_t        acc_d, acc_q;
  acc_t        sh;
  logic [ACC_W-COORD_WIDTH:0] hi;
  coord_t      sat_d, res_q;

  assign en6 = !v6_q || res_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign wgt_ready_o = en4;
  assign res_o.valid = v6_q;
  assign res_o.curve_value = res_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = $signed(wgt_i.pts[i]) * $signed(wgt_i.wgts[i]);
    end
  end

  assign acc_d = $signed(prod_q[0]) + $signed(prod_q[1]) + $signed(prod_q[2])
               + $signed(prod_q[3])
               + ((kind4_q == KIND_CATMULL) ? HALF_CR : HALF_BZ);

  assign sh = (kind5_q == KIND_CATMULL) ? (acc_q >>> SHIFT_CR) : (acc_q >>> SHIFT_BZ);
  assign hi = sh[ACC_W-1:COORD_WIDTH-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat_d = sh[COORD_WIDTH-1:0];
    end else if (sh[ACC_W-1]) begin
      sat_d = COORD_MIN;
    end else begin
      sat_d = COORD_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= wgt_valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      prod_q  <= prod_d;
      kind4_q <= wgt_i.kind;
    end
    if (en5) begin
      acc_q   <= acc_d;
      kind5_q <= kind4_q;
    end
    if (en6) begin
      res_q <= sat_d;
    end
  end

endmodule

FILE: hw/rtl/pce_checker.sv
// Port-level checker of the curve evaluator and its bind to the top level.
`include "parametric_curve_evaluator_unit_assert.svh"

module pce_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input pce_pkg::coord_t out_value_i
);
  import pce_pkg::*;

  logic [DEPTH_W-1:0] count_d, count_q;
  logic               in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (in_acc && !out_acc) begin
      count_d = count_q + DEPTH_W'(1);
    end else if (!in_acc && out_acc) begin
      count_d = count_q - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  `PCE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `PCE_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_value_i))
  `PCE_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, out_valid_i, count_q != '0)
  `PCE_ASSERT_NOW(a_depth, clk_i, rst_ni, 1'b1, count_q <= DEPTH_W'(PIPE_DEPTH))

endmodule

bind parametric_curve_evaluator_unit pce_checker u_pce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_value_i (res_o.curve_value)
);
